### rtl/mpfd_pkg.sv
// Shared types and constants for the page framebuffer drawing engine.
`timescale 1ns / 1ps
package mpfd_pkg;
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W = 10;
    localparam int COORD_W = 14;

    typedef enum logic [2:0] {
        OP_PIXEL = 3'd0,
        OP_HLINE = 3'd1,
        OP_VLINE = 3'd2,
        OP_OUTLINE = 3'd3,
        OP_FILL = 3'd4,
        OP_READ = 3'd5
    } op_t;

    localparam logic [1:0] PEN_CLEAR = 2'd0;
    localparam logic [1:0] PEN_SET = 2'd1;
    localparam logic [1:0] PEN_INVERT = 2'd2;

    // One segment for the byte walker: a line, vertical or horizontal.
    typedef struct packed {
        logic vertical;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] len;
    } seg_t;

    // Applies a pen to a byte under a mask.
    function automatic logic [7:0] pen_apply(input logic [7:0] d, input logic [7:0] m,
                                             input logic [1:0] pen);
        logic [7:0] r;
        r = d;
        case (pen)
            PEN_CLEAR: r = d & ~m;
            PEN_SET: r = d | m;
            PEN_INVERT: r = d ^ m;
            default: r = d;
        endcase
        return r;
    endfunction
endpackage

### rtl/mpfd_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module mpfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### rtl/mpfd_walker.sv
// Byte walker: clips one segment and applies read-modify-write to each byte.
`timescale 1ns / 1ps
module mpfd_walker #(
    parameter int SCREEN_WIDTH = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  mpfd_pkg::seg_t       seg,
    input  logic [1:0]           pen,
    output logic                 busy,
    output logic                 mem_we,
    output logic [mpfd_pkg::ADDR_W-1:0] mem_addr,
    output logic [7:0]           mem_wdata,
    input  logic [7:0]           mem_rdata
);
    import mpfd_pkg::*;

    typedef enum logic [1:0] {
        W_IDLE,
        W_CLIP,
        W_READ,
        W_WRITE
    } wstate_t;

    localparam int IDX_W = 16;
    localparam logic signed [COORD_W-1:0] SW = COORD_W'(SCREEN_WIDTH);
    localparam logic signed [COORD_W-1:0] SH = COORD_W'(SCREEN_HEIGHT);

    wstate_t state_reg, state_next;
    seg_t seg_reg, seg_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic signed [COORD_W-1:0] rem_reg, rem_next;
    logic [2:0] off_reg, off_next;
    logic [7:0] mask_reg, mask_next;

    logic signed [COORD_W-1:0] cx, cy, clen, cend;
    logic signed [COORD_W-1:0] modv;
    logic [7:0] vmask;
    logic in_store;

    // Clipping of the held segment.
    always_comb
    begin
        cx = seg_reg.x;
        cy = seg_reg.y;
        clen = seg_reg.len;
        if (seg_reg.vertical)
        begin
            if (cy < 0)
            begin
                clen = clen + cy;
                cy = '0;
            end
            cend = cy + clen;
            if (cend > SH)
            begin
                clen = SH - cy;
            end
        end
        else
        begin
            if (cx < 0)
            begin
                clen = clen + cx;
                cx = '0;
            end
            cend = cx + clen;
            if (cend > SW)
            begin
                clen = SW - cx;
            end
        end
    end

    // Mask for the next vertical byte given remaining rows and bit offset.
    always_comb
    begin
        modv = COORD_W'(8) - COORD_W'(off_reg);
        if (rem_reg >= modv)
        begin
            vmask = 8'hFF << off_reg;
        end
        else
        begin
            vmask = (8'hFF >> (4'd8 - rem_reg[3:0])) << off_reg;
        end
    end

    assign in_store = (idx_reg < IDX_W'(STORE_DEPTH));
    assign busy = (state_reg != W_IDLE);
    assign mem_addr = idx_reg[ADDR_W-1:0];
    assign mem_we = (state_reg == W_WRITE) && in_store;
    assign mem_wdata = pen_apply(mem_rdata, mask_reg, pen);

    always_comb
    begin
        state_next = state_reg;
        seg_next = seg_reg;
        idx_next = idx_reg;
        rem_next = rem_reg;
        off_next = off_reg;
        mask_next = mask_reg;
        unique case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    seg_next = seg;
                    state_next = W_CLIP;
                end
            end
            W_CLIP:
            begin
                state_next = W_IDLE;
                if (seg_reg.vertical)
                begin
                    if (cx >= 0 && cx < SW && clen > 0)
                    begin
                        idx_next = IDX_W'(cx) + IDX_W'(cy >>> 3) * IDX_W'(SCREEN_WIDTH);
                        off_next = cy[2:0];
                        rem_next = clen;
                        state_next = W_READ;
                    end
                end
                else
                begin
                    if (cy >= 0 && cy < SH && clen > 0)
                    begin
                        idx_next = IDX_W'(cx) + IDX_W'(cy >>> 3) * IDX_W'(SCREEN_WIDTH);
                        off_next = cy[2:0];
                        rem_next = clen;
                        state_next = W_READ;
                    end
                end
            end
            W_READ:
            begin
                if (seg_reg.vertical)
                begin
                    mask_next = vmask;
                end
                else
                begin
                    mask_next = 8'h01 << off_reg;
                end
                state_next = W_WRITE;
            end
            W_WRITE:
            begin
                if (seg_reg.vertical)
                begin
                    rem_next = rem_reg - modv;
                    off_next = '0;
                    idx_next = idx_reg + IDX_W'(SCREEN_WIDTH);
                end
                else
                begin
                    rem_next = rem_reg - COORD_W'(1);
                    idx_next = idx_reg + IDX_W'(1);
                end
                state_next = (rem_next > 0) ? W_READ : W_IDLE;
            end
            default: state_next = W_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
        idx_reg <= idx_next;
        rem_reg <= rem_next;
        off_reg <= off_next;
        mask_reg <= mask_next;
    end
endmodule

### rtl/mono_page_framebuffer_draw.sv
// Top level of the page framebuffer drawing engine.
//  channel | direction | signals
//  in      | input     | in_valid, in_ready, operation, pos_x, pos_y, extent_w, extent_h,
//          |           | pen, read_address
//  out     | output    | out_valid, out_ready, read_data, finished_operation
// After reset a clearing pass writes zero to all 1024 bytes before ready rises.
// Each touched byte costs one read-modify-write on the single store port,
// plus an issue, a clip and a hand-back step per segment.
// One item is in work at a time; a waiting result blocks the next item.
`timescale 1ns / 1ps
module mono_page_framebuffer_draw #(
    parameter int SCREEN_WIDTH = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic signed [11:0] pos_x,
    input  logic signed [11:0] pos_y,
    input  logic signed [11:0] extent_w,
    input  logic signed [11:0] extent_h,
    input  logic [1:0]  pen,
    input  logic [9:0]  read_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic [2:0]  finished_operation
);
    import mpfd_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_READ,
        S_READ2,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [ADDR_W:0] clr_reg, clr_next;
    logic [2:0] op_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg, w_reg, h_reg, col_reg, col_next;
    logic [1:0] pen_reg;
    logic [ADDR_W-1:0] raddr_reg;
    logic [1:0] part_reg, part_next;
    logic [7:0] data_reg, data_next;
    logic [2:0] fop_reg;
    logic out_valid_reg, out_valid_next;

    seg_t seg;
    logic w_start, w_busy, w_we;
    logic [ADDR_W-1:0] w_addr, m_addr;
    logic [7:0] w_wdata, m_wdata, m_rdata;
    logic m_we;
    logic accept;
    logic last_seg;
    logic signed [COORD_W-1:0] fill_hi;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign read_data = data_reg;
    assign finished_operation = fop_reg;

    // Segment for the current part of the shape.
    always_comb
    begin
        seg.vertical = 1'b0;
        seg.x = x_reg;
        seg.y = y_reg;
        seg.len = w_reg;
        last_seg = 1'b1;
        fill_hi = x_reg + w_reg;
        if (fill_hi > COORD_W'(SCREEN_WIDTH))
        begin
            fill_hi = COORD_W'(SCREEN_WIDTH);
        end
        case (op_reg)
            OP_PIXEL: seg.len = COORD_W'(1);
            OP_VLINE:
            begin
                seg.vertical = 1'b1;
                seg.len = h_reg;
            end
            OP_OUTLINE:
            begin
                last_seg = (part_reg == 2'd3);
                case (part_reg)
                    2'd1: seg.y = y_reg + h_reg - COORD_W'(1);
                    2'd2:
                    begin
                        seg.vertical = 1'b1;
                        seg.len = h_reg;
                    end
                    2'd3:
                    begin
                        seg.vertical = 1'b1;
                        seg.len = h_reg;
                        seg.x = x_reg + w_reg - COORD_W'(1);
                    end
                    default: ;
                endcase
            end
            OP_FILL:
            begin
                seg.vertical = 1'b1;
                seg.len = h_reg;
                seg.x = col_reg;
                last_seg = (col_reg + COORD_W'(1) >= fill_hi);
            end
            default: ;
        endcase
    end

    // A fill whose column range is empty finishes without starting the walker.
    assign w_start = (state_reg == S_ISSUE) && !(op_reg == OP_FILL && col_reg >= fill_hi);

    mpfd_walker #(
        .SCREEN_WIDTH(SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_walker (
        .clk(clk),
        .rst_n(rst_n),
        .start(w_start),
        .seg(seg),
        .pen(pen_reg),
        .busy(w_busy),
        .mem_we(w_we),
        .mem_addr(w_addr),
        .mem_wdata(w_wdata),
        .mem_rdata(m_rdata)
    );

    always_comb
    begin
        m_we = w_we;
        m_addr = w_addr;
        m_wdata = w_wdata;
        if (state_reg == S_CLEAR)
        begin
            m_we = 1'b1;
            m_addr = clr_reg[ADDR_W-1:0];
            m_wdata = '0;
        end
        else if (state_reg == S_READ)
        begin
            m_we = 1'b0;
            m_addr = raddr_reg;
        end
    end

    mpfd_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .clk(clk),
        .we(m_we),
        .addr(m_addr),
        .wdata(m_wdata),
        .rdata(m_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        part_next = part_reg;
        col_next = col_reg;
        data_next = data_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (ADDR_W+1)'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    part_next = '0;
                    col_next = (pos_x < 0) ? '0 : COORD_W'(pos_x);
                    data_next = '0;
                    if (operation == OP_READ)
                    begin
                        state_next = S_READ;
                    end
                    else if (operation <= OP_FILL)
                    begin
                        state_next = S_ISSUE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_ISSUE:
            begin
                if (op_reg == OP_FILL && col_reg >= fill_hi)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!w_busy)
                begin
                    if (last_seg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        part_next = part_reg + 2'd1;
                        col_next = col_reg + COORD_W'(1);
                        state_next = S_ISSUE;
                    end
                end
            end
            S_READ: state_next = S_READ2;
            S_READ2:
            begin
                data_next = m_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= operation;
            x_reg <= COORD_W'(pos_x);
            y_reg <= COORD_W'(pos_y);
            w_reg <= COORD_W'(extent_w);
            h_reg <= COORD_W'(extent_h);
            pen_reg <= pen;
            raddr_reg <= read_address;
            fop_reg <= operation;
        end
        part_reg <= part_next;
        col_reg <= col_next;
        data_reg <= data_next;
    end
endmodule

### rtl/mpfd_checker.sv
// Port-level checker for the drawing engine, bound to the top level.
`timescale 1ns / 1ps
module mpfd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] read_data,
    input logic [2:0] finished_operation
);
    import mpfd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data))
        else $error("result dropped while stalled");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after acceptance");

    a_ready_vs_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("new item taken while a result waits");

    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished_operation != OP_READ |-> read_data == 8'd0)
        else $error("nonzero data for a drawing command");
endmodule

bind mono_page_framebuffer_draw mpfd_checker u_mpfd_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .finished_operation(finished_operation)
);

### dv/tb_mono_page_framebuffer_draw.sv
// Self-checking testbench for the page framebuffer drawing engine.
`timescale 1ns / 1ps
module tb_mono_page_framebuffer_draw;
    import mpfd_pkg::*;

    localparam int SCR_W = 128;
    localparam int SCR_H = 64;
    localparam int DEPTH = 1024;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct {
        logic [2:0] op;
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic signed [11:0] w;
        logic signed [11:0] h;
        logic [1:0] pen;
        logic [9:0] addr;
    } draw_cmd_t;

    typedef struct {
        logic [7:0] data;
        logic [2:0] op;
    } draw_done_t;

    class draw_scoreboard;
        logic [7:0] pixels [DEPTH];
        draw_done_t pending [$];
        int errors;

        function new();
            foreach (pixels[i]) pixels[i] = 8'h00;
            errors = 0;
        endfunction

        function void touch_byte(int idx, logic [7:0] m, logic [1:0] pn);
            if (idx < 0 || idx >= DEPTH) return;
            case (pn)
                PEN_CLEAR: pixels[idx] = pixels[idx] & ~m;
                PEN_SET: pixels[idx] = pixels[idx] | m;
                PEN_INVERT: pixels[idx] = pixels[idx] ^ m;
                default: ;
            endcase
        endfunction

        function void row_span(int x, int y, int w, logic [1:0] pn);
            if (y < 0 || y >= SCR_H) return;
            if (x < 0)
            begin
                w += x;
                x = 0;
            end
            if (x + w > SCR_W) w = SCR_W - x;
            for (int i = 0; i < w; i++)
                touch_byte(x + i + (y / 8) * SCR_W, 8'(1 << (y & 7)), pn);
        endfunction

        function void column_span(int x, int y, int h, logic [1:0] pn);
            int idx;
            int rem;
            int lead;
            logic [7:0] m;
            if (x < 0 || x >= SCR_W) return;
            if (y < 0)
            begin
                h += y;
                y = 0;
            end
            if (y + h > SCR_H) h = SCR_H - y;
            if (h <= 0) return;
            idx = x + (y / 8) * SCR_W;
            rem = h;
            if ((y & 7) != 0)
            begin
                lead = 8 - (y & 7);
                m = 8'hFF << (8 - lead);
                if (rem < lead) m = m & (8'hFF >> (lead - rem));
                touch_byte(idx, m, pn);
                if (rem <= lead) return;
                rem -= lead;
                idx += SCR_W;
            end
            while (rem >= 8)
            begin
                touch_byte(idx, 8'hFF, pn);
                idx += SCR_W;
                rem -= 8;
            end
            if (rem > 0) touch_byte(idx, 8'hFF >> (8 - rem), pn);
        endfunction

        function void note_command(draw_cmd_t c);
            draw_done_t r;
            int x, y, w, h, lo, hi;
            x = c.x;
            y = c.y;
            w = c.w;
            h = c.h;
            r.data = 8'h00;
            r.op = c.op;
            case (c.op)
                OP_PIXEL: row_span(x, y, 1, c.pen);
                OP_HLINE: row_span(x, y, w, c.pen);
                OP_VLINE: column_span(x, y, h, c.pen);
                OP_OUTLINE:
                begin
                    row_span(x, y, w, c.pen);
                    row_span(x, y + h - 1, w, c.pen);
                    column_span(x, y, h, c.pen);
                    column_span(x + w - 1, y, h, c.pen);
                end
                OP_FILL:
                begin
                    lo = x < 0 ? 0 : x;
                    hi = (x + w > SCR_W) ? SCR_W : x + w;
                    for (int i = lo; i < hi; i++) column_span(i, y, h, c.pen);
                end
                OP_READ: r.data = pixels[c.addr];
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [7:0] d, logic [2:0] op);
            draw_done_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result data=%h op=%0d", d, op);
                return;
            end
            e = pending.pop_front();
            if (d !== e.data || op !== e.op)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected data=%h op=%0d, got data=%h op=%0d",
                             e.data, e.op, d, op);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [2:0] operation;
    logic signed [11:0] pos_x, pos_y, extent_w, extent_h;
    logic [1:0] pen;
    logic [9:0] read_address;
    logic out_valid;
    logic out_ready;
    logic [7:0] read_data;
    logic [2:0] finished_operation;

    draw_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    longint cycles;

    mono_page_framebuffer_draw #(.SCREEN_WIDTH(SCR_W), .SCREEN_HEIGHT(SCR_H)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .pos_x(pos_x), .pos_y(pos_y),
        .extent_w(extent_w), .extent_h(extent_h), .pen(pen),
        .read_address(read_address),
        .out_valid(out_valid), .out_ready(out_ready),
        .read_data(read_data), .finished_operation(finished_operation)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(read_data, finished_operation);
    end

    // Valid stays high after an acceptance so that a following transaction can
    // start at the same edge; it drops only while the sender idles.
    task automatic send_command(draw_cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= c.op;
        pos_x <= c.x;
        pos_y <= c.y;
        extent_w <= c.w;
        extent_h <= c.h;
        pen <= c.pen;
        read_address <= c.addr;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_command(c);
    endtask

    function automatic logic signed [11:0] pick_coord(int span);
        case ($urandom_range(9))
            0: return 12'($urandom);
            1: return 12'sh800;
            2: return 12'sd2047;
            3: return -12'($urandom_range(20));
            default: return 12'($urandom_range(span + 8));
        endcase
    endfunction

    function automatic draw_cmd_t random_command();
        draw_cmd_t c;
        c.op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        c.x = pick_coord(SCR_W);
        c.y = pick_coord(SCR_H);
        // Keep most extents small so that fills stay short.
        c.w = ($urandom_range(7) == 0) ? pick_coord(SCR_W) : 12'($urandom_range(24)) - 12'sd2;
        c.h = ($urandom_range(7) == 0) ? pick_coord(SCR_H) : 12'($urandom_range(24)) - 12'sd2;
        c.pen = ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2));
        c.addr = ($urandom_range(1)) ? 10'($urandom) : 10'($urandom_range(SCR_W * SCR_H / 8 - 1));
        return c;
    endfunction

    function automatic draw_cmd_t make_cmd(logic [2:0] op, int x, int y, int w, int h,
                                           logic [1:0] pn, int a);
        draw_cmd_t c;
        c.op = op;
        c.x = 12'(x);
        c.y = 12'(y);
        c.w = 12'(w);
        c.h = 12'(h);
        c.pen = pn;
        c.addr = 10'(a);
        return c;
    endfunction

    initial
    begin
        draw_cmd_t dir [$];
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = '0;
        pos_x = '0;
        pos_y = '0;
        extent_w = '0;
        extent_h = '0;
        pen = '0;
        read_address = '0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        dir.push_back(make_cmd(OP_READ, 0, 0, 0, 0, PEN_SET, 1023));
        dir.push_back(make_cmd(OP_PIXEL, 0, 0, 0, 0, PEN_SET, 0));
        dir.push_back(make_cmd(OP_PIXEL, 127, 63, 0, 0, PEN_SET, 0));
        dir.push_back(make_cmd(OP_PIXEL, -1, 64, 0, 0, PEN_SET, 0));
        dir.push_back(make_cmd(OP_HLINE, -2048, 9, 4095, 0, PEN_SET, 0));
        dir.push_back(make_cmd(OP_HLINE, 5, 10, -3, 0, PEN_SET, 0));
        dir.push_back(make_cmd(OP_VLINE, 3, 3, 2, 0, PEN_INVERT, 0));
        dir.push_back(make_cmd(OP_VLINE, 7, -5, 2047, 2047, PEN_SET, 0));
        dir.push_back(make_cmd(OP_VLINE, 8, 5, 13, 20, PEN_SET, 0));
        dir.push_back(make_cmd(OP_OUTLINE, 2, 2, 10, 10, PEN_INVERT, 0));
        dir.push_back(make_cmd(OP_OUTLINE, 20, 4, 0, 6, PEN_SET, 0));
        dir.push_back(make_cmd(OP_OUTLINE, 30, 4, 6, -1, PEN_SET, 0));
        dir.push_back(make_cmd(OP_OUTLINE, 40, 40, 1, 1, PEN_INVERT, 0));
        dir.push_back(make_cmd(OP_FILL, 100, 50, 40, 40, PEN_INVERT, 0));
        dir.push_back(make_cmd(OP_FILL, 0, 0, 3, 64, PEN_CLEAR, 0));
        dir.push_back(make_cmd(OP_FILL, 60, 20, 4, 4, 2'd3, 0));
        dir.push_back(make_cmd(3'd6, 1, 1, 1, 1, PEN_SET, 5));
        dir.push_back(make_cmd(3'd7, 1, 1, 1, 1, PEN_SET, 5));
        for (int i = 0; i < 4; i++)
            dir.push_back(make_cmd(OP_READ, 0, 0, 0, 0, PEN_SET, i * 128 + 7));
        dir.push_back(make_cmd(OP_READ, 0, 0, 0, 0, PEN_SET, 1023));
        foreach (dir[i]) send_command(dir[i]);

        // Long receiver hold-off while commands keep arriving.
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 10; i++) send_command(random_command());
        join

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 67 : 0;
            recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 15 : 0;
            for (int i = 0; i < 240; i++) send_command(random_command());
        end
        in_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
